/* hdl/bc3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc3_pkg: shared types and constants of the 3x3 binary closing block
// Image size limits, field widths, register indexes and the step record that
// travels from the classifier to the datapath.
// ----------------------------------------------------------------------------
package bc3_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_HEIGHT  = 1024;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  // Row counters run a few rows past the image while the flush completes.
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT + 5);
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [PIX_W-1:0] FOREGROUND = 8'hFF;
  localparam logic [PIX_W-1:0] BACKGROUND = 8'h00;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Which neighbors of a window center lie inside the image.
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } win_mask_t;

  // One classified item: what each pass does with it.
  typedef struct packed {
    logic      in_we;
    logic      in_bit;
    logic      in_slot;
    col_t      in_col;
    logic      dil_we;
    logic      dil_slot;
    col_t      dil_col;
    win_mask_t dil_mask;
    logic      ero_emit;
    win_mask_t ero_mask;
    logic      row_end;
    logic      frame_end;
  } step_t;

endpackage

/* hdl/binary_closing_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_closing_3x3: streaming 3x3 binary morphological closing
// Dilates and then erodes a raster pixel stream with a 3x3 square.
// ----------------------------------------------------------------------------
// Send pixels in raster order, one transaction per pixel, with frame_start set
// on the first pixel of each frame; a pixel of 255 is foreground, any other
// value background. The block accepts one transaction per clock while its queue
// has room and returns the closed image as 0/255 pixels. The closed pixel for an
// image position comes out 2*image_width+2 input transactions after the pixel at
// that position, so after the last pixel of a frame send 2*image_width+2 drain
// transactions (mode = 1) to push the rest out; extra drains give no result.
// Each accepted transaction passes the queue and the b and c step registers
// before it reaches the output register. Neighbors outside the image are
// ignored in both passes. A classifier tracks positions, a four-entry queue
// decouples it from the datapath, and the datapath stalls only while its output
// register is full. Write image_width and image_height only between frames.
// ----------------------------------------------------------------------------
module binary_closing_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [bc3_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bc3_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Pixel input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bc3_pkg::PIX_W-1:0]     s_axis_tdata_i,  // [7:0] pixel_in
  input  logic [1:0]                    s_axis_tuser_i,  // [0] mode, [1] frame_start
  // Closed pixel output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bc3_pkg::PIX_W-1:0]     m_axis_tdata_o,  // [7:0] pixel_out
  output logic                          m_axis_tuser_o,  // [0] row_end
  output logic                          m_axis_tlast_o   // frame_end
);
  import bc3_pkg::*;

  step_t push_step, head_step;
  logic  q_ready, q_valid, pop, accept;

  // Take a transaction whenever the queue has room.
  assign s_axis_tready_o = q_ready;
  assign accept          = s_axis_tvalid_i && q_ready;

  bc3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .mode_i        (s_axis_tuser_i[0]),
    .pixel_i       (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i[1]),
    .step_o        (push_step)
  );

  bc3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (push_step),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_step)
  );

  bc3_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (q_valid),
    .head_i          (head_step),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* hdl/bc3_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc3_front: configuration registers and item classifier
// Tracks the input, dilation and erosion positions of the frame and turns
// each accepted transaction into a step record for the datapath.
// ----------------------------------------------------------------------------
module bc3_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bc3_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bc3_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         accept_i,
  input  logic                         mode_i,
  input  logic [bc3_pkg::PIX_W-1:0]    pixel_i,
  input  logic                         frame_start_i,
  output bc3_pkg::step_t               step_o
);
  import bc3_pkg::*;

  col_t width_m1_q, width_m1_d;
  row_t height_q, height_d;
  logic [31:0] wide_val;
  logic [31:0] clamp_w, clamp_h;

  row_t in_row_q, in_row_d, dil_row_q, dil_row_d, ero_row_q, ero_row_d;
  col_t in_col_q, in_col_d, dil_col_q, dil_col_d, ero_col_q, ero_col_d;
  logic done_q, done_d;

  row_t ri, rd, re;
  col_t ci, cd, ce;
  logic restart, active, dil_go, ero_go, last_item;

  // Clamp register writes into the supported range.
  always_comb begin
    wide_val = 32'(cfg_wdata_i);
    if (wide_val == 32'd0) begin
      clamp_w = 32'd1;
      clamp_h = 32'd1;
    end else begin
      clamp_w = (wide_val > MAX_WIDTH)  ? MAX_WIDTH  : wide_val;
      clamp_h = (wide_val > MAX_HEIGHT) ? MAX_HEIGHT : wide_val;
    end
    width_m1_d = width_m1_q;
    height_d   = height_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_m1_d = COL_W'(clamp_w - 32'd1);
        CFG_IMAGE_HEIGHT: height_d   = ROW_W'(clamp_h);
        default:          height_d   = height_q;
      endcase
    end
  end

  always_comb begin
    restart = !mode_i && frame_start_i;
    ri      = restart ? '0 : in_row_q;
    ci      = restart ? '0 : in_col_q;
    rd      = restart ? '0 : dil_row_q;
    cd      = restart ? '0 : dil_col_q;
    re      = restart ? '0 : ero_row_q;
    ce      = restart ? '0 : ero_col_q;
    active  = restart || !done_q;

    // Dilation trails the input by one row and one pixel, erosion by two.
    dil_go  = active && (ri > ROW_W'(1) || (ri == ROW_W'(1) && ci != '0));
    ero_go  = dil_go && (rd > ROW_W'(1) || (rd == ROW_W'(1) && cd != '0));

    step_o.in_we          = active && (ri < height_q);
    step_o.in_bit         = !mode_i && (pixel_i == FOREGROUND);
    step_o.in_slot        = ri[0];
    step_o.in_col         = ci;
    step_o.dil_we         = dil_go && (rd < height_q);
    step_o.dil_slot       = rd[0];
    step_o.dil_col        = cd;
    step_o.dil_mask.top   = (rd != '0);
    step_o.dil_mask.bot   = ((rd + ROW_W'(1)) < height_q);
    step_o.dil_mask.left  = (cd != '0);
    step_o.dil_mask.right = (cd != width_m1_q);
    step_o.ero_emit       = ero_go && (re < height_q);
    step_o.ero_mask.top   = (re != '0);
    step_o.ero_mask.bot   = ((re + ROW_W'(1)) < height_q);
    step_o.ero_mask.left  = (ce != '0);
    step_o.ero_mask.right = (ce != width_m1_q);
    step_o.row_end        = (ce == width_m1_q);
    step_o.frame_end      = step_o.row_end && ((re + ROW_W'(1)) == height_q);
    last_item             = step_o.ero_emit && step_o.frame_end;

    // Advance each position in raster order while the frame is still flushing.
    in_row_d  = ri;
    in_col_d  = ci;
    dil_row_d = rd;
    dil_col_d = cd;
    ero_row_d = re;
    ero_col_d = ce;
    if (active) begin
      in_col_d = (ci == width_m1_q) ? '0 : ci + COL_W'(1);
      in_row_d = (ci == width_m1_q) ? ri + ROW_W'(1) : ri;
    end
    if (dil_go) begin
      dil_col_d = (cd == width_m1_q) ? '0 : cd + COL_W'(1);
      dil_row_d = (cd == width_m1_q) ? rd + ROW_W'(1) : rd;
    end
    if (ero_go) begin
      ero_col_d = (ce == width_m1_q) ? '0 : ce + COL_W'(1);
      ero_row_d = (ce == width_m1_q) ? re + ROW_W'(1) : re;
    end
    done_d = !active || last_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_m1_q <= COL_W'(MAX_WIDTH - 1);
      height_q   <= ROW_W'(MAX_HEIGHT);
      in_row_q   <= '0;
      in_col_q   <= '0;
      dil_row_q  <= '0;
      dil_col_q  <= '0;
      ero_row_q  <= '0;
      ero_col_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      width_m1_q <= width_m1_d;
      height_q   <= height_d;
      if (accept_i) begin
        in_row_q  <= in_row_d;
        in_col_q  <= in_col_d;
        dil_row_q <= dil_row_d;
        dil_col_q <= dil_col_d;
        ero_row_q <= ero_row_d;
        ero_col_q <= ero_col_d;
        done_q    <= done_d;
      end
    end
  end

endmodule

/* hdl/bc3_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc3_queue: step record queue
// Short circular buffer that decouples the classifier from the datapath.
// ----------------------------------------------------------------------------
module bc3_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bc3_pkg::step_t push_data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bc3_pkg::step_t head_o
);
  import bc3_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  step_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;

  assign ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + CNT_W'(1);
    if (!push_i && pop_i) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* hdl/bc3_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc3_back: line stores, windows and output register
// Runs the dilation and erosion passes over two-row line stores and holds
// each closed pixel in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module bc3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  bc3_pkg::step_t            head_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [bc3_pkg::PIX_W-1:0] m_axis_tdata_o,
  output logic                      m_axis_tuser_o,
  output logic                      m_axis_tlast_o
);
  import bc3_pkg::*;

  localparam int unsigned STORE_DEPTH = 2 ** (COL_W + 1);

  logic in_store_q  [STORE_DEPTH];
  logic dil_store_q [STORE_DEPTH];

  logic       adv;
  logic       b_valid_q, c_valid_q, out_valid_q;
  step_t      b_step_q, c_step_q;
  logic       in_top_q, in_mid_q, dil_top_q, dil_mid_q, c_dil_bit_q;
  logic [2:0] dwin_l_q, dwin_c_q, ewin_l_q, ewin_c_q;
  logic [2:0] dnew, enew, drm, erm;
  logic       dil_bit, keep;
  logic [PIX_W-1:0] pix_q;
  logic       row_end_q, frame_end_q;

  // Move the whole datapath together; stall only while a result waits.
  assign adv   = !out_valid_q || m_axis_tready_i;
  assign pop_o = adv && head_valid_i;

  // Columns are {bottom, middle, top}.
  always_comb begin
    dnew = {b_step_q.in_bit, in_mid_q, in_top_q};
    drm  = {b_step_q.dil_mask.bot, 1'b1, b_step_q.dil_mask.top};
    dil_bit = |(dwin_l_q & drm & {3{b_step_q.dil_mask.left}})
            | |(dwin_c_q & drm)
            | |(dnew & drm & {3{b_step_q.dil_mask.right}});

    enew = {c_dil_bit_q, dil_mid_q, dil_top_q};
    erm  = {c_step_q.ero_mask.bot, 1'b1, c_step_q.ero_mask.top};
    keep = &(ewin_l_q | ~(erm & {3{c_step_q.ero_mask.left}}))
         & &(ewin_c_q | ~erm)
         & &(enew | ~(erm & {3{c_step_q.ero_mask.right}}));
  end

  // Input line store: the slot being written holds the row two above.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (head_i.in_we) in_store_q[{head_i.in_slot, head_i.in_col}] <= head_i.in_bit;
      in_top_q <= in_store_q[{head_i.in_slot, head_i.in_col}];
      in_mid_q <= in_store_q[{~head_i.in_slot, head_i.in_col}];
    end
  end

  // Dilated line store, same two-slot scheme.
  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q) begin
      if (b_step_q.dil_we) dil_store_q[{b_step_q.dil_slot, b_step_q.dil_col}] <= dil_bit;
      dil_top_q <= dil_store_q[{b_step_q.dil_slot, b_step_q.dil_col}];
      dil_mid_q <= dil_store_q[{~b_step_q.dil_slot, b_step_q.dil_col}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_step_q    <= head_i;
      c_step_q    <= b_step_q;
      c_dil_bit_q <= dil_bit;
      pix_q       <= keep ? FOREGROUND : BACKGROUND;
      row_end_q   <= c_step_q.row_end;
      frame_end_q <= c_step_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dwin_l_q    <= '0;
      dwin_c_q    <= '0;
      ewin_l_q    <= '0;
      ewin_c_q    <= '0;
    end else if (adv) begin
      b_valid_q   <= head_valid_i;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q && c_step_q.ero_emit;
      if (b_valid_q) begin
        dwin_l_q <= dwin_c_q;
        dwin_c_q <= dnew;
      end
      if (c_valid_q) begin
        ewin_l_q <= ewin_c_q;
        ewin_c_q <= enew;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = pix_q;
  assign m_axis_tuser_o  = row_end_q;
  assign m_axis_tlast_o  = frame_end_q;

endmodule
